### sv/msdc_pkg.sv
`default_nettype none
package msdc_pkg;

	localparam int NUM_CHANNELS = 3;
	localparam int NUM_DIGITS   = 5;
	localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int IDX_W        = $clog2(NUM_DIGITS);
	localparam int TO_W         = 24;
	localparam int WORD_W       = 14;
	localparam int CQ_DEPTH     = 2;
	localparam int CQ_PTR_W     = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
	localparam int CQ_CNT_W     = $clog2(CQ_DEPTH + 1);

	localparam logic [TO_W-1:0]   TIMEOUT_RESET = 24'd300000;
	localparam logic [WORD_W-1:0] DOT_BIT       = 14'h080;
	localparam logic [WORD_W-1:0] UPPER_DOT_BIT = 14'h100;
	localparam logic [IDX_W-1:0]  IDX_LAST      = IDX_W'(NUM_DIGITS - 1);

	// ceil(2^38 / 1000): floor(x / 1000) == (x * SEC_RECIP) >> 38 for any 32-bit x
	localparam int PROD_W    = 61;
	localparam int SEC_SHIFT = 38;
	localparam logic [28:0] SEC_RECIP = 29'd274877907;

	typedef struct packed {
		logic                    is_refresh;
		logic [NUM_CHANNELS-1:0] levels;
		logic                    temp_load;
		logic [6:0]              whole;
		logic [6:0]              frac;
	} cmd_t;

	function automatic logic [WORD_W-1:0] pos_bit(input int p);
		return WORD_W'(14'h200 << p);
	endfunction

	function automatic logic [WORD_W-1:0] seg_of(input logic [3:0] d);
		logic [WORD_W-1:0] s;
		case (d)
			4'd0: s = 14'h03F;
			4'd1: s = 14'h014;
			4'd2: s = 14'h06D;
			4'd3: s = 14'h05D;
			4'd4: s = 14'h056;
			4'd5: s = 14'h05B;
			4'd6: s = 14'h07B;
			4'd7: s = 14'h015;
			4'd8: s = 14'h07F;
			4'd9: s = 14'h05F;
			default: s = '0;
		endcase
		return s;
	endfunction

	// v <= 99, so v*205 >> 11 is v/10
	function automatic logic [3:0] tens_of(input logic [6:0] v);
		logic [14:0] m;
		m = 15'(v) * 15'd205;
		return m[14:11];
	endfunction

	function automatic logic [3:0] ones_of(input logic [6:0] v);
		logic [6:0] t;
		t = 7'(tens_of(v)) * 7'd10;
		return 4'(v - t);
	endfunction

	function automatic logic [6:0] clamp99(input logic [PROD_W-SEC_SHIFT-1:0] q);
		return (q > (PROD_W-SEC_SHIFT)'(99)) ? 7'd99 : q[6:0];
	endfunction

endpackage
`default_nettype wire

### sv/msdc_front.sv
`default_nettype none
module msdc_front (
	input  wire logic                  push,
	output logic                       full,
	input  wire logic                  operation,
	input  wire logic [2:0]            switch_levels,
	input  wire logic                  temp_valid,
	input  wire logic [15:0]           temp_raw,
	input  wire logic                  q_full,
	output logic                       wr_en,
	output msdc_pkg::cmd_t             cmd
);

	logic [11:0] quarters;
	logic [9:0]  whole_raw;
	logic        fault;

	assign full     = q_full;
	assign wr_en    = push && !q_full;
	assign quarters = temp_raw[14:3];
	assign whole_raw = quarters[11:2];
	assign fault    = temp_raw[2];

	always_comb begin
		cmd.is_refresh = operation;
		cmd.levels     = switch_levels[msdc_pkg::NUM_CHANNELS-1:0];
		cmd.temp_load  = temp_valid;
		if (fault) begin
			cmd.whole = '0;
			cmd.frac  = '0;
		end else begin
			cmd.whole = (whole_raw > 10'd99) ? 7'd99 : whole_raw[6:0];
			cmd.frac  = 7'({5'b0, quarters[1:0]}) * 7'd25;
		end
	end

endmodule
`default_nettype wire

### sv/msdc_cmd_q.sv
`default_nettype none
module msdc_cmd_q (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr_en,
	input  wire msdc_pkg::cmd_t wr_cmd,
	output logic                full,
	input  wire logic           rd_en,
	output logic                rd_valid,
	output msdc_pkg::cmd_t      rd_cmd
);

	msdc_pkg::cmd_t                   entry_q [msdc_pkg::CQ_DEPTH];
	logic [msdc_pkg::CQ_PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [msdc_pkg::CQ_CNT_W-1:0]    count_q;

	assign full     = (count_q == msdc_pkg::CQ_CNT_W'(msdc_pkg::CQ_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= (wr_ptr_q == msdc_pkg::CQ_PTR_W'(msdc_pkg::CQ_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			if (rd_en)
				rd_ptr_q <= (rd_ptr_q == msdc_pkg::CQ_PTR_W'(msdc_pkg::CQ_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			if (wr_en && !rd_en)
				count_q <= count_q + 1'b1;
			else if (rd_en && !wr_en)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			entry_q[wr_ptr_q] <= wr_cmd;
	end

endmodule
`default_nettype wire

### sv/msdc_back.sv
`default_nettype none
module msdc_back (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [msdc_pkg::TO_W-1:0]           cfg_wdata,
	input  wire logic                                cmd_valid,
	input  wire msdc_pkg::cmd_t                      cmd,
	output logic                                     cmd_pop,
	input  wire logic                                pop,
	output logic                                     empty,
	output logic [msdc_pkg::WORD_W-1:0]              display_word,
	output logic [2:0]                               digit_index,
	output logic                                     last_word
);

	localparam int NC = msdc_pkg::NUM_CHANNELS;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_MUL_A = 4'b0010,
		ST_MUL_B = 4'b0100,
		ST_BUILD = 4'b1000
	} back_state_t;

	back_state_t                          state_q;
	logic [NC-1:0]                        run_q;
	logic [31:0]                          millis_q [NC];
	logic [msdc_pkg::TO_W-1:0]            timeout_q, idle_to_q;
	logic [6:0]                           temp_whole_q, temp_frac_q;
	logic [1:0]                           cnt_q;
	logic [msdc_pkg::CH_W-1:0]            ch_a_q, ch_b_q;
	logic                                 tzero_q;
	logic [msdc_pkg::WORD_W-1:0]          shown_q [msdc_pkg::NUM_DIGITS];
	logic                                 emit_q;
	logic [msdc_pkg::IDX_W-1:0]           idx_q;
	logic [msdc_pkg::PROD_W-1:0]          prod_q;
	logic [6:0]                           sec_a_q;
	logic                                 odd_a_q;

	// scan results
	logic [NC-1:0]                        run_n, clr_n;
	logic                                 reload_n;
	logic [1:0]                           cnt_n;
	logic [msdc_pkg::CH_W-1:0]            ch_a_n, ch_b_n;
	logic [msdc_pkg::TO_W-1:0]            timeout_n;

	logic                                 take, build_ok;
	logic [msdc_pkg::CH_W-1:0]            mul_sel;
	logic [31:0]                          mul_in;
	logic [6:0]                           sec_b;
	logic                                 odd_b;
	logic [msdc_pkg::WORD_W-1:0]          words_n [msdc_pkg::NUM_DIGITS];

	assign take     = (state_q == ST_IDLE) && cmd_valid;
	assign cmd_pop  = take;
	assign build_ok = !emit_q || (pop && idx_q == msdc_pkg::IDX_LAST);
	assign mul_sel  = (state_q == ST_MUL_A) ? ch_a_q : ch_b_q;
	assign mul_in   = millis_q[mul_sel];
	assign sec_b    = msdc_pkg::clamp99(prod_q[msdc_pkg::PROD_W-1:msdc_pkg::SEC_SHIFT]);
	assign odd_b    = prod_q[msdc_pkg::SEC_SHIFT];

	assign empty        = !emit_q;
	assign display_word = shown_q[idx_q];
	assign digit_index  = 3'(idx_q);
	assign last_word    = (idx_q == msdc_pkg::IDX_LAST);

	// switch scan; stops after the second pressed channel
	always_comb begin
		run_n    = run_q;
		clr_n    = '0;
		reload_n = 1'b0;
		cnt_n    = 2'd0;
		ch_a_n   = '0;
		ch_b_n   = '0;
		for (int i = 0; i < NC; i++) begin
			if (cnt_n < 2'd2) begin
				if (!cmd.levels[i]) begin
					clr_n[i] = !run_q[i];
					run_n[i] = 1'b1;
					reload_n = 1'b1;
					if (cnt_n == 2'd0)
						ch_a_n = msdc_pkg::CH_W'(i);
					else
						ch_b_n = msdc_pkg::CH_W'(i);
					cnt_n = cnt_n + 2'd1;
				end else begin
					run_n[i] = 1'b0;
				end
			end
		end
		timeout_n = reload_n ? idle_to_q : timeout_q;
	end

	// new display words
	always_comb begin
		for (int p = 0; p < msdc_pkg::NUM_DIGITS; p++)
			words_n[p] = shown_q[p];
		if (cnt_q == 2'd1) begin
			if (32'(ch_a_q) < 32'd2) begin
				words_n[0] = msdc_pkg::pos_bit(0) | msdc_pkg::seg_of(msdc_pkg::tens_of(sec_a_q));
				words_n[1] = msdc_pkg::pos_bit(1) | msdc_pkg::seg_of(msdc_pkg::ones_of(sec_a_q));
				words_n[3] = msdc_pkg::pos_bit(3) |
					msdc_pkg::seg_of(msdc_pkg::tens_of(temp_whole_q));
				words_n[4] = msdc_pkg::pos_bit(4) |
					msdc_pkg::seg_of(msdc_pkg::ones_of(temp_whole_q));
				words_n[2] = odd_a_q ? (msdc_pkg::pos_bit(2) | msdc_pkg::UPPER_DOT_BIT) : '0;
			end else begin
				words_n[0] = msdc_pkg::pos_bit(0) |
					msdc_pkg::seg_of(msdc_pkg::tens_of(temp_whole_q));
				words_n[1] = msdc_pkg::pos_bit(1) |
					msdc_pkg::seg_of(msdc_pkg::ones_of(temp_whole_q));
				words_n[3] = msdc_pkg::pos_bit(3) | msdc_pkg::seg_of(msdc_pkg::tens_of(sec_a_q));
				words_n[4] = msdc_pkg::pos_bit(4) | msdc_pkg::seg_of(msdc_pkg::ones_of(sec_a_q));
				words_n[2] = odd_a_q ? (msdc_pkg::pos_bit(2) | msdc_pkg::DOT_BIT) : '0;
			end
		end else if (cnt_q == 2'd2) begin
			words_n[0] = msdc_pkg::pos_bit(0) | msdc_pkg::seg_of(msdc_pkg::tens_of(sec_a_q));
			words_n[1] = msdc_pkg::pos_bit(1) | msdc_pkg::seg_of(msdc_pkg::ones_of(sec_a_q));
			words_n[3] = msdc_pkg::pos_bit(3) | msdc_pkg::seg_of(msdc_pkg::tens_of(sec_b));
			words_n[4] = msdc_pkg::pos_bit(4) | msdc_pkg::seg_of(msdc_pkg::ones_of(sec_b));
			// old word 2 keeps its other bits; dots follow the two parities
			words_n[2] = shown_q[2] | msdc_pkg::pos_bit(2);
			words_n[2][8] = odd_a_q;
			words_n[2][7] = odd_b;
		end
		if (tzero_q) begin
			words_n[0] = msdc_pkg::pos_bit(0) | msdc_pkg::seg_of(msdc_pkg::tens_of(temp_whole_q));
			words_n[1] = msdc_pkg::pos_bit(1) | msdc_pkg::seg_of(msdc_pkg::ones_of(temp_whole_q));
			words_n[3] = msdc_pkg::pos_bit(3) | msdc_pkg::seg_of(msdc_pkg::tens_of(temp_frac_q));
			words_n[4] = msdc_pkg::pos_bit(4) | msdc_pkg::seg_of(msdc_pkg::ones_of(temp_frac_q));
			words_n[2] = msdc_pkg::pos_bit(2) | msdc_pkg::DOT_BIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			run_q        <= '0;
			for (int i = 0; i < NC; i++)
				millis_q[i] <= '0;
			timeout_q    <= '0;
			idle_to_q    <= msdc_pkg::TIMEOUT_RESET;
			temp_whole_q <= '0;
			temp_frac_q  <= '0;
			cnt_q        <= '0;
			ch_a_q       <= '0;
			ch_b_q       <= '0;
			tzero_q      <= 1'b0;
			for (int p = 0; p < msdc_pkg::NUM_DIGITS; p++)
				shown_q[p] <= '0;
			emit_q       <= 1'b0;
			idx_q        <= '0;
		end else begin
			if (cfg_we)
				idle_to_q <= cfg_wdata;

			case (state_q)
				ST_IDLE: begin
					if (take && !cmd.is_refresh) begin
						for (int i = 0; i < NC; i++)
							if (run_q[i])
								millis_q[i] <= millis_q[i] + 32'd1;
						if (timeout_q != '0)
							timeout_q <= timeout_q - 1'b1;
					end else if (take) begin
						run_q <= run_n;
						for (int i = 0; i < NC; i++)
							if (clr_n[i])
								millis_q[i] <= '0;
						timeout_q <= timeout_n;
						tzero_q   <= (timeout_n == '0);
						cnt_q     <= cnt_n;
						ch_a_q    <= ch_a_n;
						ch_b_q    <= ch_b_n;
						if (cmd.temp_load) begin
							temp_whole_q <= cmd.whole;
							temp_frac_q  <= cmd.frac;
						end
						state_q <= ST_MUL_A;
					end
				end
				ST_MUL_A: state_q <= ST_MUL_B;
				ST_MUL_B: state_q <= ST_BUILD;
				ST_BUILD: begin
					if (build_ok) begin
						for (int p = 0; p < msdc_pkg::NUM_DIGITS; p++)
							shown_q[p] <= words_n[p];
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			// a build may start in the beat that pops the previous last word
			if (state_q == ST_BUILD && build_ok) begin
				emit_q <= 1'b1;
				idx_q  <= '0;
			end else if (pop && emit_q) begin
				if (idx_q == msdc_pkg::IDX_LAST)
					emit_q <= 1'b0;
				else
					idx_q <= idx_q + 1'b1;
			end
		end
	end

	// seconds: one shared reciprocal multiply, first channel then second
	always_ff @(posedge clk) begin
		if (state_q == ST_MUL_A || state_q == ST_MUL_B)
			prod_q <= msdc_pkg::PROD_W'(mul_in) * msdc_pkg::PROD_W'(msdc_pkg::SEC_RECIP);
		if (state_q == ST_MUL_B) begin
			sec_a_q <= msdc_pkg::clamp99(prod_q[msdc_pkg::PROD_W-1:msdc_pkg::SEC_SHIFT]);
			odd_a_q <= prod_q[msdc_pkg::SEC_SHIFT];
		end
	end

endmodule
`default_nettype wire

### sv/multi_stopwatch_display_controller.sv
`default_nettype none
// channel   handshake        payload
// ------    ---------------  ------------------------------------------------
// input     push / full      operation, switch_levels, temp_valid, temp_raw
// result    empty / pop      display_word, digit_index, last_word
// config    cfg_we           cfg_wdata (idle timeout, 24 bit)
//
// Items go through a two-entry command queue; a tick is applied in the idle
// state. A refresh goes through a scan, two passes through the one 32x29
// reciprocal multiplier and a build, and then five result words; the words
// of one refresh overlap the scan and multiplies of the next.
// Reset clears the control state at once, no clearing pass; the queue entries
// and multiplier registers are not reset; the idle timeout loads 300000.
// With pop low the words hold and the next build waits; the queue then fills
// and full rises.
module multi_stopwatch_display_controller (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [23:0] cfg_wdata,
	input  wire logic        push,
	output logic             full,
	input  wire logic        operation,
	input  wire logic [2:0]  switch_levels,
	input  wire logic        temp_valid,
	input  wire logic [15:0] temp_raw,
	output logic             empty,
	input  wire logic        pop,
	output logic [13:0]      display_word,
	output logic [2:0]       digit_index,
	output logic             last_word
);

	msdc_pkg::cmd_t wr_cmd, rd_cmd;
	logic           wr_en, q_full, rd_en, rd_valid;

	msdc_front u_front (
		.push          (push),
		.full          (full),
		.operation     (operation),
		.switch_levels (switch_levels),
		.temp_valid    (temp_valid),
		.temp_raw      (temp_raw),
		.q_full        (q_full),
		.wr_en         (wr_en),
		.cmd           (wr_cmd)
	);

	msdc_cmd_q u_cmd_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_cmd   (wr_cmd),
		.full     (q_full),
		.rd_en    (rd_en),
		.rd_valid (rd_valid),
		.rd_cmd   (rd_cmd)
	);

	msdc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.cmd_valid    (rd_valid),
		.cmd          (rd_cmd),
		.cmd_pop      (rd_en),
		.pop          (pop),
		.empty        (empty),
		.display_word (display_word),
		.digit_index  (digit_index),
		.last_word    (last_word)
	);

	// words of one refresh leave in index order
	a_word_order: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !last_word) |=>
			(!empty && digit_index == $past(digit_index) + 3'd1))
		else $error("display word index skipped");

	// a refresh always starts at word 0
	a_first_word: assert property (@(posedge clk) disable iff (!arst_n)
		empty |=> (empty || digit_index == 3'd0))
		else $error("refresh did not start at word 0");

	// a new refresh only follows a popped last word
	a_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && last_word) |=> (empty || digit_index == 3'd0))
		else $error("words continued past the last word");

endmodule
`default_nettype wire
